FILE: hdl/ktqs_pkg.sv
package ktqs_pkg;

  localparam int KEY_W = 16;
  localparam int TAG_W = 8;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } ktqs_entry_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_POP,
    S_POP_W,
    S_PIV,
    S_CMP,
    S_SWP,
    S_SWP2,
    S_FIN,
    S_FIN2,
    S_PUSHL,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } ktqs_state_t;

endpackage

FILE: hdl/ktqs_in_if.sv
interface ktqs_in_if;
  import ktqs_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;
  logic [TAG_W-1:0] tag;
  logic             final_item;

  modport source (output valid, output key, output tag, output final_item, input ready);
  modport sink (input valid, input key, input tag, input final_item, output ready);
endinterface

FILE: hdl/ktqs_out_if.sv
interface ktqs_out_if;
  import ktqs_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] sorted_key;
  logic [TAG_W-1:0] sorted_tag;
  logic             end_of_list;

  modport source (output valid, output sorted_key, output sorted_tag, output end_of_list,
                  input ready);
  modport sink (input valid, input sorted_key, input sorted_tag, input end_of_list,
                output ready);
endinterface

FILE: hdl/ktqs_ram.sv
module ktqs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/key_tag_quicksort_unit.sv
// Collects up to MAX_ITEMS key and tag pairs, one pair per cycle, until a transfer marked
// final_item; later pairs beyond MAX_ITEMS are dropped. The stored list is then sorted in
// place by an in-place quicksort (Lomuto partition, last element as pivot, left range first)
// and streamed out in ascending key order, the last pair flagged end_of_list. The input is
// not ready from the final transfer until the last result has been taken. All pairs sit in
// a RAM with one read port and one write port: a partition reads each pair of its range
// once and passes through two extra states, S_SWP and S_SWP2, for every swap that moves
// a pair, and each result is read, loaded and offered in turn, the next one only after
// the last has been taken.
module key_tag_quicksort_unit #(
  parameter int MAX_ITEMS = 16
) (
  input logic        clk,
  input logic        rst_n,
  ktqs_in_if.sink    in_ch,
  ktqs_out_if.source out_ch
);
  import ktqs_pkg::*;

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int EW = $bits(ktqs_entry_t);

  ktqs_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic [IW-1:0] lo_r, lo_nxt;
  logic [IW-1:0] hi_r, hi_nxt;
  logic [IW-1:0] fill_r, fill_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [IW-1:0] k_r, k_nxt;
  ktqs_entry_t   pivot_r, pivot_nxt;
  ktqs_entry_t   hold_r, hold_nxt;
  ktqs_entry_t   out_entry_r, out_entry_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  ktqs_entry_t   mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata_raw;
  ktqs_entry_t   mem_rdata;

  logic            stk_we;
  logic [IW-1:0]   stk_waddr;
  logic [2*IW-1:0] stk_wdata;
  logic [IW-1:0]   stk_raddr;
  logic [2*IW-1:0] stk_rdata;

  logic in_xfer;
  logic out_xfer;
  logic right_ok;
  logic left_ok;

  ktqs_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_pair_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata_raw)
  );

  ktqs_ram #(.WIDTH(2 * IW), .DEPTH(MAX_ITEMS)) u_range_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign mem_rdata = ktqs_entry_t'(mem_rdata_raw);

  assign in_ch.ready        = (state_r == S_LOAD);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.sorted_key  = out_entry_r.key;
  assign out_ch.sorted_tag  = out_entry_r.tag;
  assign out_ch.end_of_list = out_last_r;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  // The pivot settles at fill; sub-ranges are pushed only when they hold two or more pairs.
  assign right_ok = {1'b0, hi_r} > ({1'b0, fill_r} + (IW+1)'(1));
  assign left_ok  = {1'b0, fill_r} > ({1'b0, lo_r} + (IW+1)'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    fill_r      <= fill_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    pivot_r     <= pivot_nxt;
    hold_r      <= hold_nxt;
    out_entry_r <= out_entry_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sp_nxt        = sp_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    fill_nxt      = fill_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    pivot_nxt     = pivot_r;
    hold_nxt      = hold_r;
    out_entry_nxt = out_entry_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;

    mem_we    = 1'b0;
    mem_waddr = fill_r;
    mem_wdata = hold_r;
    mem_raddr = j_r;
    stk_we    = 1'b0;
    stk_waddr = IW'(sp_r);
    stk_wdata = {lo_r, hi_r};
    stk_raddr = IW'(sp_r - CW'(1));

    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (count_r < CW'(MAX_ITEMS)) begin
            mem_we        = 1'b1;
            mem_waddr     = IW'(count_r);
            mem_wdata.key = in_ch.key;
            mem_wdata.tag = in_ch.tag;
            count_nxt     = count_r + CW'(1);
          end
          if (in_ch.final_item) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        if (count_r < CW'(2)) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = {IW'(0), IW'(count_r - CW'(1))};
          sp_nxt    = CW'(1);
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          sp_nxt    = sp_r - CW'(1);
          state_nxt = S_POP_W;
        end
      end
      S_POP_W: begin
        lo_nxt    = stk_rdata[2*IW-1:IW];
        hi_nxt    = stk_rdata[IW-1:0];
        fill_nxt  = stk_rdata[2*IW-1:IW];
        j_nxt     = stk_rdata[2*IW-1:IW];
        mem_raddr = stk_rdata[IW-1:0];
        state_nxt = S_PIV;
      end
      S_PIV: begin
        pivot_nxt = mem_rdata;
        mem_raddr = j_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if ((mem_rdata.key <= pivot_r.key) && (fill_r != j_r)) begin
          hold_nxt  = mem_rdata;
          mem_raddr = fill_r;
          state_nxt = S_SWP;
        end else begin
          if (mem_rdata.key <= pivot_r.key) begin
            fill_nxt = fill_r + IW'(1);
          end
          j_nxt = j_r + IW'(1);
          if (j_r + IW'(1) == hi_r) begin
            mem_raddr = fill_nxt;
            state_nxt = S_FIN;
          end else begin
            mem_raddr = j_r + IW'(1);
          end
        end
      end
      S_SWP: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = mem_rdata;
        state_nxt = S_SWP2;
      end
      S_SWP2: begin
        mem_we    = 1'b1;
        mem_waddr = fill_r;
        mem_wdata = hold_r;
        fill_nxt  = fill_r + IW'(1);
        j_nxt     = j_r + IW'(1);
        if (j_r + IW'(1) == hi_r) begin
          mem_raddr = fill_r + IW'(1);
          state_nxt = S_FIN;
        end else begin
          mem_raddr = j_r + IW'(1);
          state_nxt = S_CMP;
        end
      end
      S_FIN: begin
        hold_nxt  = mem_rdata;
        mem_we    = 1'b1;
        mem_waddr = fill_r;
        mem_wdata = pivot_r;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = hold_r;
        if (right_ok) begin
          stk_we    = 1'b1;
          stk_wdata = {fill_r + IW'(1), hi_r};
          sp_nxt    = sp_r + CW'(1);
        end
        state_nxt = S_PUSHL;
      end
      S_PUSHL: begin
        if (left_ok) begin
          stk_we    = 1'b1;
          stk_wdata = {lo_r, fill_r - IW'(1)};
          sp_nxt    = sp_r + CW'(1);
        end
        state_nxt = S_POP;
      end
      S_EMIT_RD: begin
        mem_raddr = k_r;
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        out_entry_nxt = mem_rdata;
        out_last_nxt  = ((CW'(k_r) + CW'(1)) == count_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + IW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Loading and emitting never overlap.
  assert property (@(posedge clk) disable iff (!rst_n) !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(MAX_ITEMS))
    else $error("pair count beyond capacity");

  // Pending ranges are disjoint and hold at least two pairs each.
  assert property (@(posedge clk) disable iff (!rst_n) sp_r <= CW'(MAX_ITEMS / 2))
    else $error("range stack deeper than possible");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ((j_r < hi_r) && (fill_r <= j_r) && (lo_r <= fill_r)))
    else $error("partition scan out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_ch.end_of_list) |=> (in_ch.ready && (count_r == '0)))
    else $error("block not reloaded after the last result");
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ktqs_pkg::*;

  localparam int LIST_CAP = 16;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
  } sorted_pair_t;

  logic clk = 1'b0;
  logic rst_n;

  ktqs_in_if  in_ch();
  ktqs_out_if out_ch();

  key_tag_quicksort_unit #(
    .MAX_ITEMS(LIST_CAP)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prediction state: the pairs held for the current list and the pending ranges.
  logic [KEY_W-1:0] held_key [LIST_CAP];
  logic [TAG_W-1:0] held_tag [LIST_CAP];
  int               held_count = 0;
  int               span_lo [LIST_CAP];
  int               span_hi [LIST_CAP];
  int               span_depth = 0;

  sorted_pair_t sorted_q[$];
  sorted_pair_t want;
  int           errors = 0;
  int           items_stored = 0;
  bit           steady = 1'b0;

  function automatic void swap_held(int a, int b);
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    k           = held_key[a];
    t           = held_tag[a];
    held_key[a] = held_key[b];
    held_tag[a] = held_tag[b];
    held_key[b] = k;
    held_tag[b] = t;
  endfunction

  function automatic int partition_span(int lo, int hi);
    logic [KEY_W-1:0] pivot;
    int               fill;
    pivot = held_key[hi];
    fill  = lo;
    for (int j = lo; j < hi; j++) begin
      if (held_key[j] <= pivot) begin
        swap_held(fill, j);
        fill++;
      end
    end
    swap_held(fill, hi);
    return fill;
  endfunction

  function automatic void push_span(int lo, int hi);
    if (lo < hi && span_depth < LIST_CAP) begin
      span_lo[span_depth] = lo;
      span_hi[span_depth] = hi;
      span_depth++;
    end
  endfunction

  function automatic void sort_held();
    int lo;
    int hi;
    int q;
    span_depth = 0;
    if (held_count < 2) return;
    push_span(0, held_count - 1);
    while (span_depth > 0) begin
      span_depth--;
      lo = span_lo[span_depth];
      hi = span_hi[span_depth];
      q  = partition_span(lo, hi);
      // The right range goes on the stack first so that the left one is done first.
      push_span(q + 1, hi);
      if (q > lo) push_span(lo, q - 1);
    end
  endfunction

  function automatic void take_pair(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic fin);
    sorted_pair_t r;
    if (held_count < LIST_CAP) begin
      held_key[held_count] = k;
      held_tag[held_count] = t;
      held_count++;
      items_stored++;
    end
    if (fin) begin
      sort_held();
      for (int i = 0; i < held_count; i++) begin
        r.key  = held_key[i];
        r.tag  = held_tag[i];
        r.last = (i == held_count - 1);
        sorted_q.push_back(r);
      end
      held_count = 0;
    end
  endfunction

  task automatic send_pair(input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                           input logic fin);
    while (!steady && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.key        <= k;
    in_ch.tag        <= t;
    in_ch.final_item <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    take_pair(k, t, fin);
    @(negedge clk);
  endtask

  task automatic send_list(input int len, input int key_span);
    logic [KEY_W-1:0] k;
    for (int i = 0; i < len; i++) begin
      k = (key_span == 0) ? KEY_W'($urandom_range(65535)) : KEY_W'($urandom_range(key_span));
      send_pair(k, TAG_W'($urandom_range(255)), i == len - 1);
    end
  endtask

  task automatic test_single_pair();
    send_pair(16'h1234, 8'hA5, 1'b1);
  endtask

  task automatic test_extremes();
    send_pair(16'hFFFF, 8'h00, 1'b0);
    send_pair(16'h0000, 8'hFF, 1'b1);
  endtask

  task automatic test_equal_keys();
    send_pair(16'h0007, 8'h01, 1'b0);
    send_pair(16'h0007, 8'h02, 1'b0);
    send_pair(16'h0007, 8'h03, 1'b1);
  endtask

  task automatic test_descending();
    send_pair(16'hC000, 8'h10, 1'b0);
    send_pair(16'h8000, 8'h20, 1'b0);
    send_pair(16'h0001, 8'h30, 1'b1);
  endtask

  // Sixteen pairs fill the store; the two after them are dropped, the last of which
  // still starts the sort.
  task automatic test_overflow();
    for (int i = 0; i < LIST_CAP + 2; i++)
      send_pair(KEY_W'($urandom_range(65535)), TAG_W'(i), i == LIST_CAP + 1);
  endtask

  task automatic test_random_lists(input int target);
    int goal;
    int len;
    goal = items_stored + target;
    while (items_stored < goal) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(LIST_CAP + 4, LIST_CAP + 1)
                                     : $urandom_range(LIST_CAP, 1);
      // Half of the lists draw keys from a narrow range so that duplicates are common.
      send_list(len, $urandom_range(1) ? 0 : $urandom_range(7, 1));
    end
  endtask

  task automatic test_steady_stream(input int target);
    steady = 1'b1;
    test_random_lists(target);
    steady = 1'b0;
  endtask

  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sorted_q.size() == 0) begin
        $error("result with nothing expected: sorted_key %h sorted_tag %h",
               out_ch.sorted_key, out_ch.sorted_tag);
        errors++;
      end else begin
        want = sorted_q.pop_front();
        if (out_ch.sorted_key !== want.key) begin
          $error("sorted_key: expected %h, got %h", want.key, out_ch.sorted_key);
          errors++;
        end
        if (out_ch.sorted_tag !== want.tag) begin
          $error("sorted_tag: expected %h, got %h", want.tag, out_ch.sorted_tag);
          errors++;
        end
        if (out_ch.end_of_list !== want.last) begin
          $error("end_of_list: expected %b, got %b", want.last, out_ch.end_of_list);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.key        = '0;
    in_ch.tag        = '0;
    in_ch.final_item = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_single_pair();
    test_extremes();
    test_equal_keys();
    test_descending();
    test_overflow();
    test_random_lists(200);
    test_steady_stream(60);
    test_random_lists(40);
    in_ch.valid <= 1'b0;

    for (int w = 0; w < 100000 && sorted_q.size() != 0; w++) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sorted_q.size() != 0) begin
      $error("%0d sorted pairs never arrived", sorted_q.size());
      errors++;
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
hdl/ktqs_pkg.sv
hdl/ktqs_in_if.sv
hdl/ktqs_out_if.sv
hdl/ktqs_ram.sv
hdl/key_tag_quicksort_unit.sv
bench/tb_top.sv
